[src/kpst_pkg.sv]
`timescale 1ns / 1ps
package kpst_pkg;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_LOAD_POINT  = 2'd0,
    CMD_LOAD_KERNEL = 2'd1,
    CMD_RUN         = 2'd2
  } cmd_t;

  // Configuration register indexes
  localparam logic CFG_ACTIVE_ROWS = 1'b0;
  localparam logic CFG_MAX_ITER    = 1'b1;

  localparam int ROWS_W = 7;
  localparam int ITER_W = 20;
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 7;
  localparam int DATA_W = 32;

  localparam logic [ROWS_W-1:0] ACTIVE_ROWS_RST = 7'd64;
  localparam logic [ITER_W-1:0] MAX_ITER_RST    = 20'd1000;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD_PT,
    OP_LOAD_K,
    OP_M_MUL,
    OP_M_WR,
    OP_PIV_MIN,
    OP_U_START,
    OP_U_STEP,
    OP_U_WR,
    OP_S_MUL,
    OP_S_WR,
    OP_R_INIT,
    OP_R_MUL1,
    OP_R_SUB,
    OP_R_MUL2,
    OP_R_CMP,
    OP_PIV_REM,
    OP_X_MUL,
    OP_X_WR,
    OP_X_CLR,
    OP_SUM,
    OP_OUT,
    OP_OUT_NONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   a_pivot;      // label/score read at pivot instead of j
    logic   w_pivot;      // weight read at pivot instead of j
    logic   k_row_pivot;  // kernel row is pivot instead of j
    logic   k_col_j;      // kernel column is j instead of pivot
  } dp_cmd_t;

  typedef struct packed {
    logic min_le0;   // smallest margin of the pass is <= 0
    logic w_zero;    // weight read data is exactly zero
    logic rem_go;    // a removal candidate with positive margin exists
    logic div_done;  // quotient ready
    logic out_free;  // output register can take a result
    logic any_sup;   // at least one nonzero weight in the summary scan
  } dp_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOOP,
    ST_M_RD,
    ST_M_MUL,
    ST_M_WR,
    ST_DECIDE,
    ST_U_RD,
    ST_U_DIV0,
    ST_U_DIV,
    ST_U_WR,
    ST_S_RD,
    ST_S_MUL,
    ST_S_WR,
    ST_R_RD,
    ST_R_MUL1,
    ST_R_SUB,
    ST_R_MUL2,
    ST_R_CMP,
    ST_R_END,
    ST_X_RD,
    ST_X_MUL,
    ST_X_WR,
    ST_X_CLR,
    ST_ITER_END,
    ST_Y_RD,
    ST_Y_ACC,
    ST_O_RD,
    ST_O_CHK,
    ST_O_NONE
  } state_t;

endpackage

[src/kernel_perceptron_support_trainer_core.sv]
`timescale 1ns / 1ps
// Kernel perceptron support trainer.
// Input stream (s_*): tuser carries the command. Load-point and load-kernel
// transfers each write one entry. A run transfer trains in place on the
// stored labels, scores, weights and kernel matrix.
// Each training iteration runs a margin pass, then either a weight update
// (the serial divider, then a score pass) or a removal search over the
// nonzero weights, followed, if a support is removed, by a score pass.
// n is the active row count; there is a single shared multiplier and a
// single read port on each memory. After the last iteration a summary
// scan and an output scan run over the n active rows.
// Output stream (m_*): one transfer per support point in increasing index
// order, tlast on the final one; if no weight is nonzero, one transfer with
// the index-valid flag low. The input stays not ready until the run's output
// scan is done; a stalled receiver holds the output scan.
// Reset clears control state and restores active_rows=64, max_iterations=1000;
// point and kernel stores are undefined until loaded. Stored margins read zero.
module kernel_perceptron_support_trainer_core #(
  parameter int MAX_POINTS  = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [143:0] s_tdata,  // row_index, column_index, label, score, weight, kernel_value
  input  logic [1:0]   s_tuser,  // command
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [71:0]  m_tdata,  // support_index, iterations_used, converged, min_margin,
                                 // nonpositive_count
  output logic         m_tuser,  // index_valid
  output logic         m_tlast,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [19:0]  cfg_data
);

  localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  kpst_pkg::dp_cmd_t           cmd;
  kpst_pkg::dp_stat_t          stat;
  logic [PW-1:0]               j;
  logic [kpst_pkg::ITER_W-1:0] iter, out_iter;
  logic                        done, out_conv;
  logic [kpst_pkg::IDX_W-1:0]  out_index;
  logic signed [kpst_pkg::DATA_W-1:0] out_min;
  logic [kpst_pkg::CNT_W-1:0]  out_npos;

  kpst_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_cmd(s_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .j(j), .iter(iter), .done(done), .stat(stat)
  );

  kpst_datapath #(.MAX_POINTS(MAX_POINTS), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk(clk), .rst(rst),
    .cmd(cmd), .j(j), .iter(iter), .done(done),
    .in_row(s_tdata[5:0]), .in_col(s_tdata[11:6]),
    .in_label(s_tdata[43:12]), .in_score(s_tdata[75:44]),
    .in_weight(s_tdata[107:76]), .in_kv(s_tdata[139:108]),
    .stat(stat),
    .out_ready(m_tready), .out_valid(m_tvalid),
    .out_index(out_index), .out_index_valid(m_tuser), .out_last(m_tlast),
    .out_iter(out_iter), .out_conv(out_conv), .out_min(out_min), .out_npos(out_npos)
  );

  assign m_tdata = {6'b0, out_npos, out_min, out_conv, out_iter, out_index};

endmodule

[src/kpst_ram.sv]
`timescale 1ns / 1ps
module kpst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/kpst_datapath.sv]
`timescale 1ns / 1ps
module kpst_datapath #(
  parameter int MAX_POINTS = 64,
  parameter int VALUE_WIDTH = 32,
  localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  kpst_pkg::dp_cmd_t                 cmd,
  input  logic [PW-1:0]                     j,
  input  logic [kpst_pkg::ITER_W-1:0]       iter,
  input  logic                              done,
  input  logic [kpst_pkg::IDX_W-1:0]        in_row,
  input  logic [kpst_pkg::IDX_W-1:0]        in_col,
  input  logic signed [kpst_pkg::DATA_W-1:0] in_label,
  input  logic signed [kpst_pkg::DATA_W-1:0] in_score,
  input  logic signed [kpst_pkg::DATA_W-1:0] in_weight,
  input  logic signed [kpst_pkg::DATA_W-1:0] in_kv,
  output kpst_pkg::dp_stat_t                stat,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [kpst_pkg::IDX_W-1:0]        out_index,
  output logic                              out_index_valid,
  output logic                              out_last,
  output logic [kpst_pkg::ITER_W-1:0]       out_iter,
  output logic                              out_conv,
  output logic signed [kpst_pkg::DATA_W-1:0] out_min,
  output logic [kpst_pkg::CNT_W-1:0]        out_npos
);

  localparam int VW  = VALUE_WIDTH;
  localparam int WW  = 2 * VW + 2;
  localparam int QW  = VW + 17;
  localparam int CW  = $clog2(QW + 1);
  localparam int NW  = $clog2(MAX_POINTS + 1);
  localparam int KD  = MAX_POINTS * MAX_POINTS;
  localparam int KAW = $clog2(KD);

  localparam logic signed [WW-1:0] VMAX_W = {{(WW-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [WW-1:0] VMIN_W = {{(WW-VW+1){1'b1}}, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] VMAX   = VMAX_W[VW-1:0];
  localparam logic signed [VW-1:0] VMIN   = VMIN_W[VW-1:0];

  function automatic logic signed [VW-1:0] sat(input logic signed [WW-1:0] v);
    if (v > VMAX_W) begin
      sat = VMAX;
    end else if (v < VMIN_W) begin
      sat = VMIN;
    end else begin
      sat = v[VW-1:0];
    end
  endfunction

  function automatic logic [KAW-1:0] kaddr(input logic [PW-1:0] r, input logic [PW-1:0] c);
    kaddr = KAW'(KAW'(r) * KAW'(MAX_POINTS)) + KAW'(c);
  endfunction

  logic signed [VW-1:0]   lab_rd, scr_rd, wgt_rd, kv_rd, mar_rd;
  logic signed [2*VW-1:0] prod;
  logic signed [VW-1:0]   qm;
  logic signed [VW-1:0]   mul_a, mul_b;
  logic signed [VW-1:0]   t, delta, minv, bestm, mmin;
  logic [PW-1:0]          best, rbest, pivot, lastsup;
  logic                   found, any_sup;
  logic [NW-1:0]          npos;
  logic [MAX_POINTS-1:0]  mvalid;
  logic                   mvalid_q;

  // divider
  logic [QW-1:0] dq;
  logic [VW-1:0] rem;
  logic [CW-1:0] cnt;
  logic          neg, den0, dpos, dneg;
  logic signed [VW:0] diff;
  logic [VW:0]   mag_n;
  logic [VW-1:0] mag_d;
  logic [VW:0]   trial;
  logic          take;
  logic signed [QW:0] qs;
  logic signed [VW-1:0] delta_v;

  logic row_ok, col_ok;
  logic [PW-1:0] row_a, col_a, pt_addr, w_addr, k_row, k_col;
  logic lab_we, scr_we, wgt_we, ker_we, mar_we;
  logic [PW-1:0] scr_waddr, wgt_waddr;
  logic signed [VW-1:0] scr_wdata, wgt_wdata;
  logic signed [VW-1:0] m_eff;
  logic                 wnz;

  assign row_ok = 7'(in_row) < 7'(MAX_POINTS);
  assign col_ok = 7'(in_col) < 7'(MAX_POINTS);
  assign row_a  = in_row[PW-1:0];
  assign col_a  = in_col[PW-1:0];

  assign pt_addr = cmd.a_pivot ? pivot : j;
  assign w_addr  = cmd.w_pivot ? pivot : j;
  assign k_row   = cmd.k_row_pivot ? pivot : j;
  assign k_col   = cmd.k_col_j ? j : pivot;

  // floor(prod / 2^16), saturated
  assign qm = sat(WW'(prod >>> 16));

  assign diff  = (VW+1)'(lab_rd) - (VW+1)'(scr_rd);
  assign mag_n = diff[VW] ? (VW+1)'(-diff) : diff;
  assign mag_d = kv_rd[VW-1] ? VW'(-kv_rd) : kv_rd;
  assign trial = {rem, dq[QW-1]};
  assign take  = trial >= {1'b0, mag_d};
  assign qs    = neg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});

  always_comb begin
    if (den0) begin
      delta_v = dpos ? VMAX : (dneg ? VMIN : '0);
    end else begin
      delta_v = sat(WW'(qs));
    end
  end

  assign m_eff = mvalid_q ? mar_rd : '0;
  assign wnz   = wgt_rd != '0;

  always_comb begin
    mul_a = lab_rd;
    mul_b = scr_rd;
    unique case (cmd.op)
      kpst_pkg::OP_S_MUL: begin
        mul_a = delta;
        mul_b = kv_rd;
      end
      kpst_pkg::OP_R_MUL1, kpst_pkg::OP_X_MUL: begin
        mul_a = wgt_rd;
        mul_b = kv_rd;
      end
      kpst_pkg::OP_R_MUL2: begin
        mul_a = lab_rd;
        mul_b = t;
      end
      default: begin
        mul_a = lab_rd;
        mul_b = scr_rd;
      end
    endcase
  end

  always_comb begin
    lab_we    = 1'b0;
    scr_we    = 1'b0;
    wgt_we    = 1'b0;
    ker_we    = 1'b0;
    mar_we    = 1'b0;
    scr_waddr = j;
    wgt_waddr = pivot;
    scr_wdata = sat(WW'(scr_rd) + WW'(qm));
    wgt_wdata = '0;
    unique case (cmd.op)
      kpst_pkg::OP_LOAD_PT: begin
        lab_we    = row_ok;
        scr_we    = row_ok;
        wgt_we    = row_ok;
        scr_waddr = row_a;
        wgt_waddr = row_a;
        scr_wdata = sat(WW'(in_score));
        wgt_wdata = sat(WW'(in_weight));
      end
      kpst_pkg::OP_LOAD_K: ker_we = row_ok && col_ok;
      kpst_pkg::OP_M_WR:   mar_we = 1'b1;
      kpst_pkg::OP_U_WR: begin
        wgt_we    = 1'b1;
        wgt_wdata = sat(WW'(wgt_rd) + WW'(delta_v));
      end
      kpst_pkg::OP_S_WR:   scr_we = 1'b1;
      kpst_pkg::OP_X_WR: begin
        scr_we    = 1'b1;
        scr_wdata = sat(WW'(scr_rd) - WW'(qm));
      end
      kpst_pkg::OP_X_CLR:  wgt_we = 1'b1;
      default: ;
    endcase
  end

  kpst_ram #(.WIDTH(VW), .DEPTH(MAX_POINTS)) u_label (
    .clk(clk), .we(lab_we), .waddr(row_a), .wdata(sat(WW'(in_label))),
    .raddr(pt_addr), .rdata(lab_rd)
  );

  kpst_ram #(.WIDTH(VW), .DEPTH(MAX_POINTS)) u_score (
    .clk(clk), .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
    .raddr(pt_addr), .rdata(scr_rd)
  );

  kpst_ram #(.WIDTH(VW), .DEPTH(MAX_POINTS)) u_weight (
    .clk(clk), .we(wgt_we), .waddr(wgt_waddr), .wdata(wgt_wdata),
    .raddr(w_addr), .rdata(wgt_rd)
  );

  kpst_ram #(.WIDTH(VW), .DEPTH(KD)) u_kernel (
    .clk(clk), .we(ker_we), .waddr(kaddr(row_a, col_a)), .wdata(sat(WW'(in_kv))),
    .raddr(kaddr(k_row, k_col)), .rdata(kv_rd)
  );

  kpst_ram #(.WIDTH(VW), .DEPTH(MAX_POINTS)) u_margin (
    .clk(clk), .we(mar_we), .waddr(j), .wdata(qm),
    .raddr(j), .rdata(mar_rd)
  );

  // datapath registers
  always_ff @(posedge clk) begin
    mvalid_q <= mvalid[j];
    unique case (cmd.op)
      kpst_pkg::OP_M_MUL, kpst_pkg::OP_S_MUL, kpst_pkg::OP_R_MUL1,
      kpst_pkg::OP_R_MUL2, kpst_pkg::OP_X_MUL: prod <= mul_a * mul_b;
      kpst_pkg::OP_M_WR: begin
        if (j == '0 || qm < minv) begin
          minv <= qm;
          best <= j;
        end
      end
      kpst_pkg::OP_PIV_MIN: pivot <= best;
      kpst_pkg::OP_PIV_REM: pivot <= rbest;
      kpst_pkg::OP_U_START: begin
        dq   <= {mag_n, 16'b0};
        rem  <= '0;
        neg  <= diff[VW] ^ kv_rd[VW-1];
        den0 <= kv_rd == '0;
        dpos <= !diff[VW] && diff != '0;
        dneg <= diff[VW];
      end
      kpst_pkg::OP_U_STEP: begin
        if (cnt != '0) begin
          rem <= take ? VW'(trial - {1'b0, mag_d}) : trial[VW-1:0];
          dq  <= {dq[QW-2:0], take};
        end
      end
      kpst_pkg::OP_U_WR:  delta <= delta_v;
      kpst_pkg::OP_R_SUB: t <= sat(WW'(scr_rd) - WW'(qm));
      kpst_pkg::OP_R_CMP: begin
        if (!found || qm > bestm) begin
          bestm <= qm;
          rbest <= j;
        end
      end
      kpst_pkg::OP_SUM: begin
        if (j == '0 || m_eff < mmin) begin
          mmin <= m_eff;
        end
        npos <= ((j == '0) ? '0 : npos) + NW'(m_eff <= 0);
        if (wnz) begin
          lastsup <= j;
        end
      end
      default: ;
    endcase
  end

  // control-side registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mvalid    <= '0;
      cnt       <= '0;
      found     <= 1'b0;
      any_sup   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == kpst_pkg::OP_M_WR) begin
        mvalid[j] <= 1'b1;
      end
      if (cmd.op == kpst_pkg::OP_U_START) begin
        cnt <= CW'(QW);
      end else if (cmd.op == kpst_pkg::OP_U_STEP && cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
      if (cmd.op == kpst_pkg::OP_R_INIT) begin
        found <= 1'b0;
      end else if (cmd.op == kpst_pkg::OP_R_CMP) begin
        found <= 1'b1;
      end
      if (cmd.op == kpst_pkg::OP_SUM) begin
        any_sup <= ((j == '0) ? 1'b0 : any_sup) | wnz;
      end
      if (cmd.op == kpst_pkg::OP_OUT || cmd.op == kpst_pkg::OP_OUT_NONE) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.op == kpst_pkg::OP_OUT || cmd.op == kpst_pkg::OP_OUT_NONE) begin
      out_index       <= (cmd.op == kpst_pkg::OP_OUT) ? kpst_pkg::IDX_W'(j) : '0;
      out_index_valid <= cmd.op == kpst_pkg::OP_OUT;
      out_last        <= (cmd.op == kpst_pkg::OP_OUT_NONE) || (j == lastsup);
      out_iter        <= iter;
      out_conv        <= done;
      out_min         <= kpst_pkg::DATA_W'(mmin);
      out_npos        <= kpst_pkg::CNT_W'(npos);
    end
  end

  assign stat.min_le0  = minv <= 0;
  assign stat.w_zero   = !wnz;
  assign stat.rem_go   = found && bestm > 0;
  assign stat.div_done = cnt == '0;
  assign stat.out_free = !out_valid || out_ready;
  assign stat.any_sup  = any_sup;

endmodule

[src/kpst_ctrl.sv]
`timescale 1ns / 1ps
module kpst_ctrl #(
  parameter int MAX_POINTS = 64,
  localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_cmd,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [kpst_pkg::ITER_W-1:0] cfg_data,
  output kpst_pkg::dp_cmd_t           cmd,
  output logic [PW-1:0]               j,
  output logic [kpst_pkg::ITER_W-1:0] iter,
  output logic                        done,
  input  kpst_pkg::dp_stat_t          stat
);

  kpst_pkg::state_t state, state_next;
  logic [PW-1:0]                 j_next;
  logic [kpst_pkg::ITER_W-1:0]   iter_next;
  logic                          done_next;
  logic [kpst_pkg::ROWS_W-1:0]   n, n_next, n_calc;
  logic [kpst_pkg::ROWS_W-1:0]   active_rows;
  logic [kpst_pkg::ITER_W-1:0]   max_iter;
  logic                          last_j;

  always_comb begin
    if (active_rows == '0) begin
      n_calc = kpst_pkg::ROWS_W'(1);
    end else if (active_rows > kpst_pkg::ROWS_W'(MAX_POINTS)) begin
      n_calc = kpst_pkg::ROWS_W'(MAX_POINTS);
    end else begin
      n_calc = active_rows;
    end
  end

  assign last_j = j == PW'(n - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= kpst_pkg::ST_IDLE;
      j           <= '0;
      iter        <= '0;
      done        <= 1'b0;
      n           <= kpst_pkg::ROWS_W'(1);
      active_rows <= kpst_pkg::ACTIVE_ROWS_RST;
      max_iter    <= kpst_pkg::MAX_ITER_RST;
    end else begin
      state <= state_next;
      j     <= j_next;
      iter  <= iter_next;
      done  <= done_next;
      n     <= n_next;
      if (cfg_we) begin
        if (cfg_index == kpst_pkg::CFG_ACTIVE_ROWS) begin
          active_rows <= cfg_data[kpst_pkg::ROWS_W-1:0];
        end else begin
          max_iter <= cfg_data;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    j_next     = j;
    iter_next  = iter;
    done_next  = done;
    n_next     = n;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.op     = kpst_pkg::OP_NONE;
    unique case (state)
      kpst_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (kpst_pkg::cmd_t'(in_cmd))
            kpst_pkg::CMD_LOAD_POINT:  cmd.op = kpst_pkg::OP_LOAD_PT;
            kpst_pkg::CMD_LOAD_KERNEL: cmd.op = kpst_pkg::OP_LOAD_K;
            kpst_pkg::CMD_RUN: begin
              n_next     = n_calc;
              iter_next  = '0;
              done_next  = 1'b0;
              state_next = kpst_pkg::ST_LOOP;
            end
            default: ;
          endcase
        end
      end
      kpst_pkg::ST_LOOP: begin
        j_next = '0;
        if (iter < max_iter && !done) begin
          state_next = kpst_pkg::ST_M_RD;
        end else begin
          state_next = kpst_pkg::ST_Y_RD;
        end
      end
      // margin pass
      kpst_pkg::ST_M_RD:  state_next = kpst_pkg::ST_M_MUL;
      kpst_pkg::ST_M_MUL: begin
        cmd.op     = kpst_pkg::OP_M_MUL;
        state_next = kpst_pkg::ST_M_WR;
      end
      kpst_pkg::ST_M_WR: begin
        cmd.op = kpst_pkg::OP_M_WR;
        if (last_j) begin
          state_next = kpst_pkg::ST_DECIDE;
        end else begin
          j_next     = j + 1'b1;
          state_next = kpst_pkg::ST_M_RD;
        end
      end
      kpst_pkg::ST_DECIDE: begin
        j_next = '0;
        if (stat.min_le0) begin
          cmd.op     = kpst_pkg::OP_PIV_MIN;
          state_next = kpst_pkg::ST_U_RD;
        end else begin
          cmd.op     = kpst_pkg::OP_R_INIT;
          state_next = kpst_pkg::ST_R_RD;
        end
      end
      // weight update at the worst point
      kpst_pkg::ST_U_RD, kpst_pkg::ST_U_DIV0, kpst_pkg::ST_U_DIV, kpst_pkg::ST_U_WR: begin
        cmd.a_pivot     = 1'b1;
        cmd.w_pivot     = 1'b1;
        cmd.k_row_pivot = 1'b1;
        priority case (state)
          kpst_pkg::ST_U_RD: state_next = kpst_pkg::ST_U_DIV0;
          kpst_pkg::ST_U_DIV0: begin
            cmd.op     = kpst_pkg::OP_U_START;
            state_next = kpst_pkg::ST_U_DIV;
          end
          kpst_pkg::ST_U_DIV: begin
            cmd.op = kpst_pkg::OP_U_STEP;
            if (stat.div_done) begin
              state_next = kpst_pkg::ST_U_WR;
            end
          end
          default: begin
            cmd.op     = kpst_pkg::OP_U_WR;
            state_next = kpst_pkg::ST_S_RD;
          end
        endcase
      end
      kpst_pkg::ST_S_RD: state_next = kpst_pkg::ST_S_MUL;
      kpst_pkg::ST_S_MUL: begin
        cmd.op     = kpst_pkg::OP_S_MUL;
        state_next = kpst_pkg::ST_S_WR;
      end
      kpst_pkg::ST_S_WR: begin
        cmd.op = kpst_pkg::OP_S_WR;
        if (last_j) begin
          state_next = kpst_pkg::ST_ITER_END;
        end else begin
          j_next     = j + 1'b1;
          state_next = kpst_pkg::ST_S_RD;
        end
      end
      // removal search, diagonal kernel entries
      kpst_pkg::ST_R_RD, kpst_pkg::ST_R_MUL1, kpst_pkg::ST_R_SUB,
      kpst_pkg::ST_R_MUL2, kpst_pkg::ST_R_CMP: begin
        cmd.k_col_j = 1'b1;
        priority case (state)
          kpst_pkg::ST_R_RD: state_next = kpst_pkg::ST_R_MUL1;
          kpst_pkg::ST_R_MUL1: begin
            cmd.op = kpst_pkg::OP_R_MUL1;
            if (!stat.w_zero) begin
              state_next = kpst_pkg::ST_R_SUB;
            end else if (last_j) begin
              state_next = kpst_pkg::ST_R_END;
            end else begin
              j_next     = j + 1'b1;
              state_next = kpst_pkg::ST_R_RD;
            end
          end
          kpst_pkg::ST_R_SUB: begin
            cmd.op     = kpst_pkg::OP_R_SUB;
            state_next = kpst_pkg::ST_R_MUL2;
          end
          kpst_pkg::ST_R_MUL2: begin
            cmd.op     = kpst_pkg::OP_R_MUL2;
            state_next = kpst_pkg::ST_R_CMP;
          end
          default: begin
            cmd.op = kpst_pkg::OP_R_CMP;
            if (last_j) begin
              state_next = kpst_pkg::ST_R_END;
            end else begin
              j_next     = j + 1'b1;
              state_next = kpst_pkg::ST_R_RD;
            end
          end
        endcase
      end
      kpst_pkg::ST_R_END: begin
        j_next = '0;
        if (stat.rem_go) begin
          cmd.op     = kpst_pkg::OP_PIV_REM;
          state_next = kpst_pkg::ST_X_RD;
        end else begin
          done_next  = 1'b1;
          state_next = kpst_pkg::ST_ITER_END;
        end
      end
      // take the removed support out of every score
      kpst_pkg::ST_X_RD, kpst_pkg::ST_X_MUL, kpst_pkg::ST_X_WR, kpst_pkg::ST_X_CLR: begin
        cmd.w_pivot = 1'b1;
        priority case (state)
          kpst_pkg::ST_X_RD: state_next = kpst_pkg::ST_X_MUL;
          kpst_pkg::ST_X_MUL: begin
            cmd.op     = kpst_pkg::OP_X_MUL;
            state_next = kpst_pkg::ST_X_WR;
          end
          kpst_pkg::ST_X_WR: begin
            cmd.op = kpst_pkg::OP_X_WR;
            if (last_j) begin
              state_next = kpst_pkg::ST_X_CLR;
            end else begin
              j_next     = j + 1'b1;
              state_next = kpst_pkg::ST_X_RD;
            end
          end
          default: begin
            cmd.op     = kpst_pkg::OP_X_CLR;
            state_next = kpst_pkg::ST_ITER_END;
          end
        endcase
      end
      kpst_pkg::ST_ITER_END: begin
        iter_next  = iter + 1'b1;
        state_next = kpst_pkg::ST_LOOP;
      end
      // summary scan over margins and weights
      kpst_pkg::ST_Y_RD: state_next = kpst_pkg::ST_Y_ACC;
      kpst_pkg::ST_Y_ACC: begin
        cmd.op = kpst_pkg::OP_SUM;
        if (last_j) begin
          j_next     = '0;
          state_next = kpst_pkg::ST_O_RD;
        end else begin
          j_next     = j + 1'b1;
          state_next = kpst_pkg::ST_Y_RD;
        end
      end
      kpst_pkg::ST_O_RD: state_next = kpst_pkg::ST_O_CHK;
      kpst_pkg::ST_O_CHK: begin
        if (stat.w_zero || stat.out_free) begin
          if (!stat.w_zero) begin
            cmd.op = kpst_pkg::OP_OUT;
          end
          if (last_j) begin
            state_next = stat.any_sup ? kpst_pkg::ST_IDLE : kpst_pkg::ST_O_NONE;
          end else begin
            j_next     = j + 1'b1;
            state_next = kpst_pkg::ST_O_RD;
          end
        end
      end
      kpst_pkg::ST_O_NONE: begin
        if (stat.out_free) begin
          cmd.op     = kpst_pkg::OP_OUT_NONE;
          state_next = kpst_pkg::ST_IDLE;
        end
      end
      default: state_next = kpst_pkg::ST_IDLE;
    endcase
  end

endmodule

[sim/kernel_perceptron_support_trainer_core_tb.sv]
`timescale 1ns / 1ps
module kernel_perceptron_support_trainer_core_tb;

  localparam int NPTS = 64;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE = 300;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MINUS_ONE = 32'hFFFF_0000;

  typedef struct {
    logic [5:0]  idx;
    logic        idx_ok;
    logic        last;
    logic [19:0] iters;
    logic        conv;
    logic [31:0] mmin;
    logic [6:0]  npos;
  } support_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [71:0]  m_tdata;
  logic         m_tuser;
  logic         m_tlast;
  logic         cfg_we = 1'b0;
  logic         cfg_index = 1'b0;
  logic [19:0]  cfg_data = '0;

  kernel_perceptron_support_trainer_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial forever #1 clk = ~clk;

  // trainer mirror state
  longint lab[NPTS], scr[NPTS], wgt[NPTS], mrg[NPTS];
  longint krn[NPTS*NPTS];
  logic [6:0]  rows_reg = 7'd64;
  logic [19:0] iter_reg = 20'd1000;

  support_t supports_due[$];
  int errors = 0;
  int runs_done = 0;
  int supports_seen = 0;
  int items_sent = 0;
  int cycles = 0;
  int hold_left = 0;
  int stall_left = 0;
  bit calm = 0;

  function automatic longint sat(longint v);
    return (v > QMAX) ? QMAX : (v < QMIN) ? QMIN : v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    return sat(p >>> 16);
  endfunction

  function automatic longint qdiv(longint num, longint den);
    if (den == 0) begin
      return (num > 0) ? QMAX : (num < 0) ? QMIN : 0;
    end
    return sat((num * 65536) / den);
  endfunction

  // one Fastron iteration; returns 1 when training has finished
  function automatic bit train_iteration(int n);
    int best;
    longint best_m, ml, delta;
    bit found;
    best = 0;
    best_m = 0;
    found = 0;
    for (int j = 0; j < n; j++) mrg[j] = qmul(lab[j], scr[j]);
    for (int j = 1; j < n; j++) if (mrg[j] < mrg[best]) best = j;
    if (mrg[best] <= 0) begin
      delta = qdiv(lab[best] - scr[best], krn[best*NPTS+best]);
      wgt[best] = sat(wgt[best] + delta);
      for (int j = 0; j < n; j++) scr[j] = sat(scr[j] + qmul(delta, krn[j*NPTS+best]));
      return 0;
    end
    for (int j = 0; j < n; j++) begin
      if (wgt[j] != 0) begin
        ml = qmul(lab[j], sat(scr[j] - qmul(wgt[j], krn[j*NPTS+j])));
        if (!found || ml > best_m) begin
          best_m = ml;
          best = j;
          found = 1;
        end
      end
    end
    if (!found || best_m <= 0) return 1;
    for (int j = 0; j < n; j++) scr[j] = sat(scr[j] - qmul(wgt[best], krn[j*NPTS+best]));
    wgt[best] = 0;
    return 0;
  endfunction

  task automatic predict_training();
    int n, iters, npos, first;
    bit done;
    longint mmin;
    support_t s;
    n = (rows_reg == 0) ? 1 : (rows_reg > NPTS) ? NPTS : rows_reg;
    iters = 0;
    done = 0;
    npos = 0;
    while (iters < iter_reg && !done) begin
      done = train_iteration(n);
      iters++;
    end
    mmin = mrg[0];
    for (int j = 0; j < n; j++) begin
      if (mrg[j] < mmin) mmin = mrg[j];
      if (mrg[j] <= 0) npos++;
    end
    s.iters = iters[19:0];
    s.conv = done;
    s.mmin = mmin[31:0];
    s.npos = npos[6:0];
    s.last = 0;
    first = supports_due.size();
    for (int j = 0; j < n; j++) begin
      if (wgt[j] != 0) begin
        s.idx = j[5:0];
        s.idx_ok = 1;
        supports_due.insert(supports_due.size(), s);
      end
    end
    if (supports_due.size() == first) begin
      s.idx = '0;
      s.idx_ok = 0;
      supports_due.insert(supports_due.size(), s);
    end
    supports_due[supports_due.size()-1].last = 1;
    runs_done++;
  endtask

  task automatic send(logic [1:0] cmd, logic [5:0] row, logic [5:0] col,
                      logic [31:0] lb, logic [31:0] sc, logic [31:0] wt, logic [31:0] kv);
    int gap;
    gap = calm ? 0 : ($urandom_range(0, 3) != 0) ? 0 :
          ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 2);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {4'b0, kv, wt, sc, lb, col, row};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    case (cmd)
      kpst_pkg::CMD_LOAD_POINT: begin
        lab[row] = longint'(signed'(lb));
        scr[row] = longint'(signed'(sc));
        wgt[row] = longint'(signed'(wt));
      end
      kpst_pkg::CMD_LOAD_KERNEL: krn[row*NPTS+col] = longint'(signed'(kv));
      kpst_pkg::CMD_RUN: predict_training();
      default: ;
    endcase
  endtask

  task automatic load_point(int r, logic [31:0] lb, logic [31:0] sc, logic [31:0] wt);
    send(kpst_pkg::CMD_LOAD_POINT, r[5:0], 6'($urandom), lb, sc, wt, $urandom);
  endtask

  task automatic load_kernel(int r, int c, logic [31:0] kv);
    send(kpst_pkg::CMD_LOAD_KERNEL, r[5:0], c[5:0], $urandom, $urandom, $urandom, kv);
  endtask

  task automatic start_run();
    send(kpst_pkg::CMD_RUN, 6'($urandom), 6'($urandom), $urandom, $urandom, $urandom,
         $urandom);
  endtask

  // wait for every result, then let the output scan finish
  task automatic drain();
    s_tvalid <= 1'b0;
    while (supports_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [19:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == kpst_pkg::CFG_ACTIVE_ROWS) rows_reg = v[6:0];
    else iter_reg = v;
  endtask

  function automatic logic [31:0] rand_label();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $urandom_range(0, 1) ? ONE : MINUS_ONE;
  endfunction

  function automatic logic [31:0] rand_small();
    int v;
    if ($urandom_range(0, 15) == 0) return $urandom;
    v = $urandom_range(0, 196608);
    return 32'(v - 98304);
  endfunction

  // n points and their n x n kernel block with random contents
  task automatic load_problem(int n);
    for (int r = 0; r < n; r++)
      load_point(r, rand_label(), rand_small(),
                 ($urandom_range(0, 2) == 0) ? rand_small() : 32'd0);
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        load_kernel(r, c, (r == c) ? (($urandom_range(0, 9) == 0) ? 32'd0 :
                    32'($urandom_range(16384, 131072))) : rand_small());
  endtask

  task automatic test_single_point();
    write_reg(kpst_pkg::CFG_ACTIVE_ROWS, 20'd1);
    write_reg(kpst_pkg::CFG_MAX_ITER, 20'hFFFFF);
    load_point(0, ONE, 32'd0, 32'd0);
    load_kernel(0, 0, ONE);
    send(CMD_UNKNOWN, 6'd0, 6'd0, ONE, ONE, ONE, ONE);
    start_run();
    start_run();
    drain();
  endtask

  task automatic test_zero_limit();
    write_reg(kpst_pkg::CFG_ACTIVE_ROWS, 20'd0);
    write_reg(kpst_pkg::CFG_MAX_ITER, 20'd0);
    start_run();
    drain();
  endtask

  task automatic test_no_supports();
    write_reg(kpst_pkg::CFG_ACTIVE_ROWS, 20'd2);
    write_reg(kpst_pkg::CFG_MAX_ITER, 20'd5);
    load_point(0, ONE, ONE, 32'd0);
    load_point(1, MINUS_ONE, MINUS_ONE, 32'd0);
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 2; c++) load_kernel(r, c, (r == c) ? ONE : 32'h0000_8000);
    start_run();
    drain();
  endtask

  task automatic test_zero_diagonal();
    write_reg(kpst_pkg::CFG_ACTIVE_ROWS, 20'd3);
    write_reg(kpst_pkg::CFG_MAX_ITER, 20'd3);
    load_point(0, ONE, MINUS_ONE, 32'd0);
    load_point(1, MINUS_ONE, ONE, 32'd0);
    load_point(2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) load_kernel(r, c, (r == c) ? 32'd0 : 32'h8000_0000);
    start_run();
    drain();
    // equal label and score on a zero diagonal gives a zero step
    load_point(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0);
    load_point(1, 32'h8000_0000, 32'h8000_0000, 32'd0);
    load_point(2, 32'd0, 32'd0, 32'h0000_0001);
    start_run();
    drain();
  endtask

  // all 64 points with no iteration, so only margins and weights are read
  task automatic test_full_size();
    calm = 1;
    write_reg(kpst_pkg::CFG_ACTIVE_ROWS, 20'd127);
    write_reg(kpst_pkg::CFG_MAX_ITER, 20'd0);
    for (int r = 0; r < NPTS; r++) load_point(r, rand_label(), rand_small(), rand_small());
    calm = 0;
    start_run();
    drain();
  endtask

  task automatic test_backpressure();
    write_reg(kpst_pkg::CFG_ACTIVE_ROWS, 20'd3);
    write_reg(kpst_pkg::CFG_MAX_ITER, 20'd4);
    load_problem(3);
    hold_left = 3000;
    start_run();
    // block stays busy behind the held output; these wait at the input
    load_point(0, rand_label(), rand_small(), rand_small());
    start_run();
    drain();
  endtask

  task automatic test_random();
    int n, start_items;
    start_items = items_sent;
    while (items_sent - start_items < 35) begin
      n = $urandom_range(1, 4);
      write_reg(kpst_pkg::CFG_ACTIVE_ROWS, 20'(n));
      write_reg(kpst_pkg::CFG_MAX_ITER, ($urandom_range(0, 4) == 0) ?
                20'($urandom_range(0, 2)) : 20'($urandom_range(3, 40)));
      calm = ($urandom_range(0, 3) == 0);
      load_problem(n);
      if ($urandom_range(0, 3) == 0)
        send(CMD_UNKNOWN, 6'($urandom), 6'($urandom), $urandom, $urandom, $urandom,
             $urandom);
      if ($urandom_range(0, 3) == 0)
        load_point($urandom_range(0, n - 1), rand_label(), rand_small(), rand_small());
      start_run();
      if ($urandom_range(0, 2) == 0) start_run();
      drain();
    end
    calm = 0;
  endtask

  // result side: compare and drive ready
  always @(posedge clk) begin
    support_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      supports_seen++;
      if (supports_due.size() == 0) begin
        $error("unexpected result transfer, index %0d", m_tdata[5:0]);
        errors++;
      end else begin
        e = supports_due.pop_front();
        if (m_tdata[5:0] !== e.idx) begin
          $error("support_index exp %0d got %0d", e.idx, m_tdata[5:0]); errors++;
        end
        if (m_tuser !== e.idx_ok) begin
          $error("index_valid exp %0d got %0d", e.idx_ok, m_tuser); errors++;
        end
        if (m_tlast !== e.last) begin
          $error("last_item exp %0d got %0d", e.last, m_tlast); errors++;
        end
        if (m_tdata[25:6] !== e.iters) begin
          $error("iterations_used exp %0d got %0d", e.iters, m_tdata[25:6]); errors++;
        end
        if (m_tdata[26] !== e.conv) begin
          $error("converged exp %0d got %0d", e.conv, m_tdata[26]); errors++;
        end
        if (m_tdata[58:27] !== e.mmin) begin
          $error("min_margin exp %h got %h", e.mmin, m_tdata[58:27]); errors++;
        end
        if (m_tdata[65:59] !== e.npos) begin
          $error("nonpositive_count exp %0d got %0d", e.npos, m_tdata[65:59]); errors++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (calm) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 9) < 7) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= 1'b0;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 2);
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_point();
    test_zero_limit();
    test_no_supports();
    test_zero_diagonal();
    test_full_size();
    test_backpressure();
    test_random();
    drain();
    $display("covered %0d input transfers, %0d training runs, %0d result transfers",
             items_sent, runs_done, supports_seen);
    $display("incl. zero diagonal, no supports, zero limit, 64 points and a held output");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
